// ===== hdl/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// Position PID package
// Field widths, fixed-point constants, register indexes and reset values
// shared by the position PID controller and its gain and sum pipeline.
// ----------------------------------------------------------------------------
package ppid_pkg;

    localparam int ANGLE_W    = 19;
    localparam int OFFSET_W   = 21;
    localparam int DUTY_W     = 16;
    localparam int POS_W      = 48;
    localparam int GAIN_W     = 16;
    localparam int ILIM_W     = 20;
    localparam int DLIM_W     = 15;
    localparam int DZ_W       = 16;
    localparam int STEP_W     = 17;
    localparam int INTEG_W    = 22;
    localparam int DELTA_W    = 20;
    localparam int TSTEP_W    = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam int LOOP_RATE_HZ_DEF = 1000;

    // Half and full turn in Q16 radians.
    localparam logic signed [DELTA_W-1:0] PI_Q16     = 20'sd205887;
    localparam logic signed [DELTA_W-1:0] TWO_PI_Q16 = 20'sd411775;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STEP    = 3'd6;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST      = 16'sd10240;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST      = 16'sd2048;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST      = -16'sd123;
    localparam logic [ILIM_W-1:0]        ILIM_RST        = 20'd6554;
    localparam logic [DLIM_W-1:0]        DLIM_RST        = 15'd0;
    localparam logic [DZ_W-1:0]          DZ_RST          = 16'd1311;
    localparam logic signed [STEP_W-1:0] TARGET_STEP_RST = 17'sd0;

    // One tick's terms, handed from the state update to the gain and sum path.
    typedef struct packed {
        logic signed [POS_W-1:0]   ep;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DELTA_W-1:0] d;
        logic                      fault;
        logic signed [POS_W-1:0]   pos;
    } ppid_term_t;

endpackage

// ===== hdl/ppid_gain_sum.sv =====
// ----------------------------------------------------------------------------
// Position PID gain and sum pipeline
// Multiplies the error, integral and velocity terms by their gains, adds and
// rounds to Q1.15, clamps to the duty limit; a fault gives zero. Four stages.
// ----------------------------------------------------------------------------
module ppid_gain_sum #(
    parameter int LOOP_RATE_HZ = ppid_pkg::LOOP_RATE_HZ_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 term_valid,
    output logic                                 term_ready,
    input  ppid_pkg::ppid_term_t                 term,
    input  logic signed [ppid_pkg::GAIN_W-1:0]   gain_p,
    input  logic signed [ppid_pkg::GAIN_W-1:0]   gain_i,
    input  logic signed [ppid_pkg::GAIN_W-1:0]   gain_d,
    input  logic [ppid_pkg::DLIM_W-1:0]          duty_limit,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ppid_pkg::DUTY_W-1:0]   duty,
    output logic signed [ppid_pkg::POS_W-1:0]    position
);
    import ppid_pkg::*;

    localparam int HALF_W = POS_W / 2;
    localparam int PLO_W  = HALF_W + 1 + GAIN_W;
    localparam int PHI_W  = HALF_W + GAIN_W;
    localparam int PD_W   = DELTA_W + GAIN_W;
    localparam int PI_W   = INTEG_W + GAIN_W;
    localparam int RATE_W = $clog2(LOOP_RATE_HZ + 1);
    localparam int V_W    = PD_W + RATE_W + 1;
    localparam int SUM_W  = 64;
    localparam int FRAC_W = 13;
    localparam int Q_W    = SUM_W - FRAC_W;

    localparam logic signed [RATE_W:0]  RATE_C = (RATE_W + 1)'(LOOP_RATE_HZ);
    localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(1) <<< (FRAC_W - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic load1, load2, load3, load4;

    logic signed [PLO_W-1:0]  pp_lo_reg;
    logic signed [PHI_W-1:0]  pp_hi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic signed [PI_W-1:0]   pi1_reg;
    logic                     fault1_reg;
    logic signed [POS_W-1:0]  pos1_reg;

    logic signed [SUM_W-1:0]  p_sum_reg;
    logic signed [V_W-1:0]    v_reg;
    logic signed [PI_W-1:0]   pi2_reg;
    logic                     fault2_reg;
    logic signed [POS_W-1:0]  pos2_reg;

    logic signed [Q_W-1:0]    q_reg;
    logic                     fault3_reg;
    logic signed [POS_W-1:0]  pos3_reg;

    logic signed [DUTY_W-1:0] duty_reg;
    logic signed [POS_W-1:0]  pos4_reg;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DUTY_W-1:0] lim;
    logic signed [Q_W-1:0]    lim_q;
    logic signed [DUTY_W-1:0] duty_next;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign term_ready = rdy1;

    assign load1 = term_valid && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;
    assign load4 = v3_reg && rdy4;

    // Adding half an LSB, then keeping the upper bits, rounds to nearest, ties upward.
    assign sum_next = p_sum_reg + SUM_W'(v_reg) + SUM_W'(pi2_reg) + ROUND_C;

    assign lim   = $signed({1'b0, duty_limit});
    assign lim_q = Q_W'(lim);

    always_comb
    begin
        priority if (fault3_reg)
        begin
            duty_next = '0;
        end
        else if (q_reg > lim_q)
        begin
            duty_next = lim;
        end
        else if (q_reg < -lim_q)
        begin
            duty_next = -lim;
        end
        else
        begin
            duty_next = q_reg[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= term_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            // The error term is split in two halves to keep each multiplier narrow.
            pp_lo_reg  <= $signed({1'b0, term.ep[HALF_W-1:0]}) * gain_p;
            pp_hi_reg  <= $signed(term.ep[POS_W-1:HALF_W]) * gain_p;
            pd_reg     <= $signed(term.d) * gain_d;
            pi1_reg    <= $signed(term.integ) * gain_i;
            fault1_reg <= term.fault;
            pos1_reg   <= term.pos;
        end
        if (load2)
        begin
            p_sum_reg  <= (SUM_W'(pp_hi_reg) <<< HALF_W) + SUM_W'(pp_lo_reg);
            v_reg      <= pd_reg * RATE_C;
            pi2_reg    <= pi1_reg;
            fault2_reg <= fault1_reg;
            pos2_reg   <= pos1_reg;
        end
        if (load3)
        begin
            q_reg      <= sum_next[SUM_W-1:FRAC_W];
            fault3_reg <= fault2_reg;
            pos3_reg   <= pos2_reg;
        end
        if (load4)
        begin
            duty_reg <= duty_next;
            pos4_reg <= pos3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign duty      = duty_reg;
    assign position  = pos4_reg;

endmodule

// ===== hdl/position_pid_with_angle_unwrap_top.sv =====
// ----------------------------------------------------------------------------
// Position PID controller with angle unwrap
// Unwraps a single-turn encoder angle into a multi-turn position and drives
// a PID loop on the position error, one control tick per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns one result per
// request, in order. Each piece of per-tick state (previous angle, position
// and target, error integral) sits in its own pipeline stage with a single
// add in its feedback path, which is what lets a new tick follow every
// cycle; the gain multiplications and the final sum run in the four stages
// after it. Stalls on the output fill bubbles first, so requests keep
// flowing as long as a stage is free. The user must write configuration only
// while the block holds no pending result; the block itself does not
// enforce this.
module position_pid_with_angle_unwrap_top #(
    parameter int LOOP_RATE_HZ = ppid_pkg::LOOP_RATE_HZ_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [18:0] encoder_angle, [39:19] target_offset
    input  logic [ppid_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] fault_latched
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] duty, [63:16] position
    output logic [ppid_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ppid_pkg::*;

    localparam int ESAT_W = 24;
    localparam int ISUM_W = ESAT_W + 1;
    localparam logic signed [ISUM_W-1:0] INTEG_MAX = ISUM_W'((1 << (INTEG_W - 1)) - 1);
    localparam logic signed [ISUM_W-1:0] INTEG_MIN = -ISUM_W'(1 << (INTEG_W - 1));

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [ILIM_W-1:0]        integral_limit_reg;
    logic [DLIM_W-1:0]        duty_limit_reg;
    logic [DZ_W-1:0]          dead_zone_reg;
    logic signed [STEP_W-1:0] target_step_reg;

    // Pipeline control.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic load1, load2, load3, load4, load5;
    logic term_ready;

    // Tick state.
    logic [ANGLE_W-1:0]        prev_angle_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic signed [POS_W-1:0]   tgt_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // Stage payloads.
    logic [ANGLE_W-1:0]         ang_s1_reg;
    logic signed [OFFSET_W-1:0] offs_s1_reg;
    logic                       fault_s1_reg;
    logic signed [DELTA_W-1:0]  d_s2_reg;
    logic signed [TSTEP_W-1:0]  dt_s2_reg;
    logic                       fault_s2_reg;
    logic signed [DELTA_W-1:0]  d_s3_reg;
    logic                       fault_s3_reg;
    logic signed [POS_W-1:0]    e_s4_reg;
    logic signed [DELTA_W-1:0]  d_s4_reg;
    logic                       fault_s4_reg;
    logic signed [POS_W-1:0]    pos_s4_reg;
    logic signed [POS_W-1:0]    ep_s5_reg;
    logic signed [DELTA_W-1:0]  d_s5_reg;
    logic                       fault_s5_reg;
    logic signed [POS_W-1:0]    pos_s5_reg;

    logic signed [DELTA_W-1:0]  diff;
    logic signed [DELTA_W-1:0]  d_next;
    logic signed [TSTEP_W-1:0]  dt_next;
    logic signed [POS_W:0]      e_full;
    logic signed [POS_W-1:0]    e_next;
    logic signed [ESAT_W-1:0]   e_sat;
    logic signed [ISUM_W-1:0]   isum;
    logic signed [INTEG_W-1:0]  isat;
    logic signed [INTEG_W-1:0]  ilim;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [POS_W:0]      e_wide;
    logic signed [POS_W:0]      dz_wide;
    logic signed [POS_W:0]      e_minus;
    logic signed [POS_W:0]      e_plus;
    logic signed [POS_W-1:0]    ep_next;

    ppid_term_t                 term;
    logic signed [DUTY_W-1:0]   duty;
    logic signed [POS_W-1:0]    position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= GAIN_P_RST;
            gain_i_reg         <= GAIN_I_RST;
            gain_d_reg         <= GAIN_D_RST;
            integral_limit_reg <= ILIM_RST;
            duty_limit_reg     <= DLIM_RST;
            dead_zone_reg      <= DZ_RST;
            target_step_reg    <= TARGET_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:         gain_p_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:         gain_i_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:         gain_d_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[ILIM_W-1:0];
                REG_DUTY_LIMIT:     duty_limit_reg     <= cfg_data[DLIM_W-1:0];
                REG_DEAD_ZONE:      dead_zone_reg      <= cfg_data[DZ_W-1:0];
                REG_TARGET_STEP:    target_step_reg    <= $signed(cfg_data[STEP_W-1:0]);
                default:            ;
            endcase
        end
    end

    assign rdy5 = !v5_reg || term_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign load1 = s_axis_tvalid && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;
    assign load4 = v3_reg && rdy4;
    assign load5 = v4_reg && rdy5;

    // Angle change, corrected once by a full turn when it goes past half a turn.
    assign diff = $signed({1'b0, ang_s1_reg}) - $signed({1'b0, prev_angle_reg});

    always_comb
    begin
        priority if (diff > PI_Q16)
        begin
            d_next = diff - TWO_PI_Q16;
        end
        else if (diff < -PI_Q16)
        begin
            d_next = diff + TWO_PI_Q16;
        end
        else
        begin
            d_next = diff;
        end
    end

    assign dt_next = TSTEP_W'(target_step_reg) + TSTEP_W'(offs_s1_reg);

    // Error of the wrapped target and position, saturated to 48 bits.
    assign e_full = (POS_W + 1)'(tgt_reg) - (POS_W + 1)'(pos_reg);

    always_comb
    begin
        if (e_full[POS_W] != e_full[POS_W-1])
        begin
            e_next = e_full[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        end
        else
        begin
            e_next = e_full[POS_W-1:0];
        end
    end

    // An error beyond 24 bits saturates the 22-bit integral either way, so the
    // integral adder only needs the error pre-saturated to 24 bits.
    always_comb
    begin
        if ((&e_s4_reg[POS_W-1:ESAT_W-1]) || !(|e_s4_reg[POS_W-1:ESAT_W-1]))
        begin
            e_sat = e_s4_reg[ESAT_W-1:0];
        end
        else
        begin
            e_sat = {e_s4_reg[POS_W-1], {(ESAT_W - 1){!e_s4_reg[POS_W-1]}}};
        end
    end

    assign isum = ISUM_W'(integ_reg) + ISUM_W'(e_sat);
    assign ilim = $signed({2'b00, integral_limit_reg});

    always_comb
    begin
        priority if (isum > INTEG_MAX)
        begin
            isat = INTEG_MAX[INTEG_W-1:0];
        end
        else if (isum < INTEG_MIN)
        begin
            isat = INTEG_MIN[INTEG_W-1:0];
        end
        else
        begin
            isat = isum[INTEG_W-1:0];
        end
    end

    always_comb
    begin
        priority if (isat > ilim)
        begin
            integ_next = ilim;
        end
        else if (isat < -ilim)
        begin
            integ_next = -ilim;
        end
        else
        begin
            integ_next = isat;
        end
    end

    // Dead zone: an error at or inside the band gives zero.
    assign e_wide  = (POS_W + 1)'(e_s4_reg);
    assign dz_wide = $signed({{(POS_W + 1 - DZ_W){1'b0}}, dead_zone_reg});
    assign e_minus = e_wide - dz_wide;
    assign e_plus  = e_wide + dz_wide;

    always_comb
    begin
        priority if (e_minus > 0)
        begin
            ep_next = e_minus[POS_W-1:0];
        end
        else if (e_plus < 0)
        begin
            ep_next = e_plus[POS_W-1:0];
        end
        else
        begin
            ep_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            prev_angle_reg <= '0;
            pos_reg        <= '0;
            tgt_reg        <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (load2)
            begin
                prev_angle_reg <= ang_s1_reg;
            end
            if (load3)
            begin
                pos_reg <= pos_reg + POS_W'(d_s2_reg);
                tgt_reg <= tgt_reg + POS_W'(dt_s2_reg);
            end
            if (load5)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            ang_s1_reg   <= s_axis_tdata[ANGLE_W-1:0];
            offs_s1_reg  <= $signed(s_axis_tdata[ANGLE_W+OFFSET_W-1:ANGLE_W]);
            fault_s1_reg <= s_axis_tuser;
        end
        if (load2)
        begin
            d_s2_reg     <= d_next;
            dt_s2_reg    <= dt_next;
            fault_s2_reg <= fault_s1_reg;
        end
        if (load3)
        begin
            d_s3_reg     <= d_s2_reg;
            fault_s3_reg <= fault_s2_reg;
        end
        if (load4)
        begin
            e_s4_reg     <= e_next;
            d_s4_reg     <= d_s3_reg;
            fault_s4_reg <= fault_s3_reg;
            pos_s4_reg   <= pos_reg;
        end
        if (load5)
        begin
            ep_s5_reg    <= ep_next;
            d_s5_reg     <= d_s4_reg;
            fault_s5_reg <= fault_s4_reg;
            pos_s5_reg   <= pos_s4_reg;
        end
    end

    // The integral register holds the value of the tick in the last stage.
    assign term.ep    = ep_s5_reg;
    assign term.integ = integ_reg;
    assign term.d     = d_s5_reg;
    assign term.fault = fault_s5_reg;
    assign term.pos   = pos_s5_reg;

    ppid_gain_sum #(
        .LOOP_RATE_HZ (LOOP_RATE_HZ)
    ) u_gain_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (v5_reg),
        .term_ready (term_ready),
        .term       (term),
        .gain_p     (gain_p_reg),
        .gain_i     (gain_i_reg),
        .gain_d     (gain_d_reg),
        .duty_limit (duty_limit_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .duty       (duty),
        .position   (position)
    );

    assign m_axis_tdata = {position, duty};

    // With the output register empty, the whole ready chain must be open.
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled while the output register is empty");

    // After the single correction the angle change never exceeds half a turn.
    a_delta_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        v2_reg |-> (d_s2_reg <= PI_Q16) && (d_s2_reg >= -PI_Q16)
    ) else $error("unwrapped angle change beyond half a turn");

    a_duty_clamp: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[DUTY_W-1:0]) <= $signed({1'b0, duty_limit_reg}))
            && ($signed(m_axis_tdata[DUTY_W-1:0]) >= -$signed({1'b0, duty_limit_reg}))
    ) else $error("duty outside the duty limit");

endmodule

// ===== sim/position_pid_with_angle_unwrap_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Position PID controller with angle unwrap: self-checking testbench
// Drives control ticks into the stream input and predicts each result with
// its own model of the unwrap, target ramp, dead band, clamped integral and
// gain sum. Results are checked field by field, in order, under random
// stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module position_pid_with_angle_unwrap_top_test;

    import ppid_pkg::*;

    localparam int     LOOP_RATE    = LOOP_RATE_HZ_DEF;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     ANGLE_MAX    = 524287;
    localparam int     OFFSET_MIN   = -1048576;
    localparam int     OFFSET_MAX   = 1048575;
    localparam longint POS_MAX      = 64'sd140737488355327;
    localparam longint INTEG_MAX    = 2097151;
    localparam longint ROUND_HALF   = 4096;
    localparam int     FRAC_SHIFT   = 13;

    // Not in the register map; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty;
        logic signed [POS_W-1:0]  position;
    } tick_result_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [18:0] encoder_angle, [39:19] target_offset
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] fault_latched
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] duty, [63:16] position
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Predictor state and its copy of the registers.
    logic [ANGLE_W-1:0]         last_angle;
    logic signed [POS_W-1:0]    unwrapped_pos;
    logic signed [POS_W-1:0]    target_pos;
    logic signed [INTEG_W-1:0]  err_integral;
    logic signed [GAIN_W-1:0]   kp, ki, kd;
    logic [ILIM_W-1:0]          integ_limit;
    logic [DLIM_W-1:0]          duty_lim;
    logic [DZ_W-1:0]            dead_band;
    logic signed [STEP_W-1:0]   tgt_step;

    tick_result_t expected_ticks[$];
    tick_result_t oldest_tick;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int error_count    = 0;
    int ticks_sent     = 0;
    int ticks_checked  = 0;
    int settings_count = 0;
    int cycle_count    = 0;

    position_pid_with_angle_unwrap_top #(
        .LOOP_RATE_HZ (LOOP_RATE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Output ready: random stalls, or a long hold-off counted down here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("result with no request pending: duty %0d position %0d",
                       $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[63:16]));
                error_count++;
            end
            else
            begin
                oldest_tick = expected_ticks.pop_front();
                if (m_axis_tdata[15:0] !== oldest_tick.duty)
                begin
                    $error("duty: expected %0d, got %0d", oldest_tick.duty,
                           $signed(m_axis_tdata[15:0]));
                    error_count++;
                end
                if (m_axis_tdata[63:16] !== oldest_tick.position)
                begin
                    $error("position: expected %0d, got %0d", oldest_tick.position,
                           $signed(m_axis_tdata[63:16]));
                    error_count++;
                end
                ticks_checked++;
            end
        end
    end

    function automatic void reset_predictor();
        last_angle    = '0;
        unwrapped_pos = '0;
        target_pos    = '0;
        err_integral  = '0;
        kp            = GAIN_P_RST;
        ki            = GAIN_I_RST;
        kd            = GAIN_D_RST;
        integ_limit   = ILIM_RST;
        duty_lim      = DLIM_RST;
        dead_band     = DZ_RST;
        tgt_step      = TARGET_STEP_RST;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:         kp          = data[GAIN_W-1:0];
            REG_GAIN_I:         ki          = data[GAIN_W-1:0];
            REG_GAIN_D:         kd          = data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: integ_limit = data[ILIM_W-1:0];
            REG_DUTY_LIMIT:     duty_lim    = data[DLIM_W-1:0];
            REG_DEAD_ZONE:      dead_band   = data[DZ_W-1:0];
            REG_TARGET_STEP:    tgt_step    = data[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // Angle change since the last tick, corrected once by a full turn when it
    // goes past half a turn either way.
    function automatic longint turn_delta(input logic [ANGLE_W-1:0] angle);
        longint dlt;
        dlt = longint'(angle) - longint'(last_angle);
        if (dlt > longint'(PI_Q16))
            dlt -= longint'(TWO_PI_Q16);
        else if (dlt < -longint'(PI_Q16))
            dlt += longint'(TWO_PI_Q16);
        return dlt;
    endfunction

    function automatic tick_result_t predict_tick(input logic [ANGLE_W-1:0] angle,
                                                  input logic signed [OFFSET_W-1:0] offset,
                                                  input logic fault);
        tick_result_t res;
        longint dlt, err, err_db, integ, drive_sum, q, lim;
        dlt           = turn_delta(angle);
        unwrapped_pos = unwrapped_pos + POS_W'(dlt);
        target_pos    = target_pos + POS_W'(longint'(tgt_step)) + POS_W'(longint'(offset));

        err = longint'(target_pos) - longint'(unwrapped_pos);
        if (err > POS_MAX)
            err = POS_MAX;
        else if (err < -POS_MAX - 1)
            err = -POS_MAX - 1;

        // The integral saturates to its own width first, then to the limit.
        integ = longint'(err_integral) + err;
        if (integ > INTEG_MAX)
            integ = INTEG_MAX;
        else if (integ < -INTEG_MAX - 1)
            integ = -INTEG_MAX - 1;
        lim = longint'(integ_limit);
        if (integ > lim)
            integ = lim;
        else if (integ < -lim)
            integ = -lim;
        err_integral = INTEG_W'(integ);

        if (err > longint'(dead_band))
            err_db = err - longint'(dead_band);
        else if (err < -longint'(dead_band))
            err_db = err + longint'(dead_band);
        else
            err_db = 0;

        drive_sum = err_db * longint'(kp) + dlt * LOOP_RATE * longint'(kd)
                  + integ * longint'(ki);
        q = (drive_sum + ROUND_HALF) >>> FRAC_SHIFT;
        lim = longint'(duty_lim);
        if (q > lim)
            q = lim;
        else if (q < -lim)
            q = -lim;
        if (fault)
            q = 0;

        last_angle   = angle;
        res.duty     = DUTY_W'(q);
        res.position = unwrapped_pos;
        return res;
    endfunction

    // Target offset that makes the next tick's position error equal want.
    function automatic logic signed [OFFSET_W-1:0] offset_for_error(
            input logic [ANGLE_W-1:0] angle, input longint want);
        longint offs;
        offs = want + longint'(unwrapped_pos) + turn_delta(angle)
             - longint'(target_pos) - longint'(tgt_step);
        if (offs > OFFSET_MAX)
            offs = OFFSET_MAX;
        else if (offs < OFFSET_MIN)
            offs = OFFSET_MIN;
        return OFFSET_W'(offs);
    endfunction

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] mask, data;
        // Bits above the register width carry junk; the block must drop them.
        mask      = CFG_DATA_W'((64'd1 << width) - 1);
        data      = (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        store_reg(idx, data);
    endtask

    task automatic load_settings(input logic signed [GAIN_W-1:0] p_gain,
                                 input logic signed [GAIN_W-1:0] i_gain,
                                 input logic signed [GAIN_W-1:0] d_gain,
                                 input logic [ILIM_W-1:0] i_lim,
                                 input logic [DLIM_W-1:0] d_lim,
                                 input logic [DZ_W-1:0] dz,
                                 input logic signed [STEP_W-1:0] stp);
        cfg_put(REG_SPARE, CFG_DATA_W'($urandom), CFG_DATA_W);
        cfg_put(REG_GAIN_P, p_gain, GAIN_W);
        cfg_put(REG_GAIN_I, i_gain, GAIN_W);
        cfg_put(REG_GAIN_D, d_gain, GAIN_W);
        cfg_put(REG_INTEGRAL_LIMIT, i_lim, ILIM_W);
        cfg_put(REG_DUTY_LIMIT, d_lim, DLIM_W);
        cfg_put(REG_DEAD_ZONE, dz, DZ_W);
        cfg_put(REG_TARGET_STEP, stp, STEP_W);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Offers one request, waits for it to be taken, then records its result.
    task automatic send_tick(input logic [ANGLE_W-1:0] angle,
                             input logic signed [OFFSET_W-1:0] offset,
                             input logic fault);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {offset, angle};
        s_axis_tuser  <= fault;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_ticks.push_back(predict_tick(angle, offset, fault));
        ticks_sent++;
    endtask

    // Mostly a shaft turning at a plausible speed, with the odd wrap-crossing
    // jump, out-of-range angle, target jump and fault.
    task automatic send_random_tick();
        int pick, ang;
        logic signed [OFFSET_W-1:0] offs;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            ang = $urandom_range(0, ANGLE_MAX);
        else if (pick < 16)
            ang = (int'(last_angle) + int'($urandom_range(150000, 261775)))
                  % int'(TWO_PI_Q16);
        else
            ang = (int'(last_angle) + int'($urandom_range(0, 60000)) - 30000
                   + int'(TWO_PI_Q16)) % int'(TWO_PI_Q16);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            offs = '0;
        else if (pick < 95)
            offs = OFFSET_W'(int'($urandom_range(0, 10000)) - 5000);
        else
            offs = OFFSET_W'($urandom);
        send_tick(ANGLE_W'(ang), offs, $urandom_range(0, 99) < 8);
    endtask

    task automatic run_random_ticks(input int count);
        repeat (count) send_random_tick();
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reset values: the duty limit is zero, so every duty must come back 0.
    task automatic test_reset_state();
        send_tick(19'd1000, 21'sd0, 1'b0);
        send_tick(19'd100000, 21'sd50000, 1'b0);
        send_tick(19'd300000, -21'sd20000, 1'b0);
        send_tick(19'd5, 21'sd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_unwrap_and_dead_zone();
        load_settings(16'sd4096, 16'sd256, -16'sd64, 20'd50000, 15'd32767,
                      16'd1000, 17'sd0);
        send_tick(19'd0, 21'sd0, 1'b0);
        send_tick(19'd411774, 21'sd0, 1'b0);   // backward through zero
        send_tick(19'd0, 21'sd0, 1'b0);        // forward through zero
        send_tick(19'd205887, 21'sd0, 1'b0);   // exactly half a turn stays
        send_tick(19'd0, 21'sd0, 1'b0);
        send_tick(19'd205888, 21'sd0, 1'b0);   // just past half a turn
        send_tick(19'd524287, 21'sd0, 1'b0);   // beyond a full turn
        send_tick(19'd0, -21'sd1048576, 1'b0);
        send_tick(19'd0, 21'sd1048575, 1'b1);  // large error while faulted
        send_tick(19'd0, 21'sd0, 1'b1);
        send_tick(19'd2000, offset_for_error(19'd2000, dead_band), 1'b0);
        send_tick(19'd2500, offset_for_error(19'd2500, -longint'(dead_band)), 1'b0);
        send_tick(19'd3000, offset_for_error(19'd3000, dead_band + 1), 1'b0);
        send_tick(19'd3000, offset_for_error(19'd3000, -longint'(dead_band) - 1), 1'b0);
        send_tick(19'd2800, offset_for_error(19'd2800, 0), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_gains();
        send_idle_pct = 23;
        recv_idle_pct = 81;
        load_settings(GAIN_W'(int'($urandom_range(0, 8191)) - 4096),
                      GAIN_W'(int'($urandom_range(0, 1023)) - 512),
                      GAIN_W'(int'($urandom_range(0, 255)) - 128),
                      ILIM_W'($urandom_range(1000, 200000)), 15'd32767,
                      DZ_W'($urandom_range(0, 3000)),
                      STEP_W'(int'($urandom_range(0, 200)) - 100));
        run_random_ticks(340);
        wait_idle();
    endtask

    task automatic test_gain_extremes();
        send_idle_pct = 81;
        recv_idle_pct = 23;
        load_settings(-16'sd32768, 16'sd32767, -16'sd32768, 20'd1048575, 15'd32767,
                      16'd0, -17'sd65536);
        run_random_ticks(340);
        wait_idle();
    endtask

    task automatic test_opposite_extremes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16'sd32767, -16'sd32768, 16'sd32767, 20'd0, 15'd1,
                      16'd65535, 17'sd65535);
        run_random_ticks(300);
        wait_idle();
    endtask

    // The output holds off long enough for the pipeline to fill and push back.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16'sd2048, 16'sd64, -16'sd16, 20'd30000, 15'd20000,
                      16'd500, 17'sd10);
        hold_request = HOLD_CYCLES;
        run_random_ticks(50);
        wait_idle();
    endtask

    initial
    begin
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_unwrap_and_dead_zone();
        test_random_gains();
        test_gain_extremes();
        test_opposite_extremes();
        test_output_backpressure();

        if (expected_ticks.size() != 0)
        begin
            $error("%0d results never arrived", expected_ticks.size());
            error_count++;
        end
        $display("Sent %0d control ticks and checked %0d results over %0d register",
                 ticks_sent, ticks_checked, settings_count);
        $display("settings, with stalls on both sides and one long output hold-off.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ppid_pkg.sv
hdl/ppid_gain_sum.sv
hdl/position_pid_with_angle_unwrap_top.sv
sim/position_pid_with_angle_unwrap_top_test.sv
